@@ rtl/sme_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme_pkg
// Shared widths, opcodes and codes of the p-code stack machine executor.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int DATA_W     = 32;
    localparam int FUNC_W     = 5;
    localparam int LEVEL_W    = 3;
    localparam int OFF_W      = 8;
    localparam int PC_OUT_W   = 10;
    localparam int KIND_W     = 2;
    localparam int ERR_W      = 2;
    localparam int CALC_W     = 34;

    localparam int MEM_WORDS_DEF   = 4096;
    localparam int NEST_LEVELS_DEF = 5;
    localparam int PROG_DEPTH_DEF  = 1024;

    localparam logic [FUNC_W-1:0] OP_LIT   = 5'd0;
    localparam logic [FUNC_W-1:0] OP_LOAD  = 5'd1;
    localparam logic [FUNC_W-1:0] OP_STORE = 5'd2;
    localparam logic [FUNC_W-1:0] OP_CALL  = 5'd3;
    localparam logic [FUNC_W-1:0] OP_RET   = 5'd4;
    localparam logic [FUNC_W-1:0] OP_INC   = 5'd5;
    localparam logic [FUNC_W-1:0] OP_JMP   = 5'd6;
    localparam logic [FUNC_W-1:0] OP_JPC   = 5'd7;
    localparam logic [FUNC_W-1:0] OP_NEG   = 5'd8;
    localparam logic [FUNC_W-1:0] OP_ADD   = 5'd9;
    localparam logic [FUNC_W-1:0] OP_SUB   = 5'd10;
    localparam logic [FUNC_W-1:0] OP_MUL   = 5'd11;
    localparam logic [FUNC_W-1:0] OP_DIV   = 5'd12;
    localparam logic [FUNC_W-1:0] OP_EQ    = 5'd13;
    localparam logic [FUNC_W-1:0] OP_LT    = 5'd14;
    localparam logic [FUNC_W-1:0] OP_GT    = 5'd15;
    localparam logic [FUNC_W-1:0] OP_NE    = 5'd16;
    localparam logic [FUNC_W-1:0] OP_LE    = 5'd17;
    localparam logic [FUNC_W-1:0] OP_GE    = 5'd18;
    localparam logic [FUNC_W-1:0] OP_PRINT = 5'd19;
    localparam logic [FUNC_W-1:0] OP_NL    = 5'd20;
    localparam logic [FUNC_W-1:0] OP_SPACE = 5'd21;
    localparam logic [FUNC_W-1:0] OP_END   = 5'd22;

    localparam logic [KIND_W-1:0] KIND_VALUE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NEWLINE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SPACE   = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DIV0  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

    typedef logic [DATA_W-1:0] word_t;

    function automatic word_t abs_mag(input word_t v);
        abs_mag = v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

@@ rtl/sme_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme_if
// Instruction and result channels of the stack machine executor.
// ----------------------------------------------------------------------------
interface sme_cmd_if
    import sme_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [LEVEL_W-1:0]       level;
    logic signed [OFF_W-1:0]  offset_or_target;
    logic signed [DATA_W-1:0] imm;

    modport source (output valid, func, level, offset_or_target, imm, input ready);
    modport sink   (input valid, func, level, offset_or_target, imm, output ready);
endinterface

interface sme_rsp_if
    import sme_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [PC_OUT_W-1:0]      next_pc;
    logic                     halted;
    logic                     print_valid;
    logic [KIND_W-1:0]        print_kind;
    logic signed [DATA_W-1:0] print_value;
    logic [ERR_W-1:0]         error;

    modport source (output valid, next_pc, halted, print_valid, print_kind, print_value,
                    error, input ready);
    modport sink   (input valid, next_pc, halted, print_valid, print_kind, print_value,
                    error, output ready);
endinterface

@@ rtl/sme_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ rtl/sme_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sme_div
    import sme_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t dividend,
    input  word_t divisor,
    output logic  done,
    output word_t quotient,
    output word_t remainder
);
    localparam int CW = $clog2(DATA_W);

    logic [CW-1:0]   cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    word_t           q_reg;
    word_t           r_reg;
    word_t           d_reg;
    logic [DATA_W:0] shifted;
    logic [DATA_W:0] diff;

    assign shifted = {r_reg, q_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                r_reg <= diff[DATA_W-1:0];
                q_reg <= {q_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted[DATA_W-1:0];
                q_reg <= {q_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule

@@ rtl/stack_machine_execute_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_execute_top
// Executes one p-code instruction per beat against a stack memory.
//
//   channel  dir  beat
//   cmd      in   one instruction: func, level, offset_or_target, imm
//   rsp      out  one result: next_pc, halted, print fields, error
//
// One instruction at a time: decode, the stack reads (up to three, pipelined
// through the single memory port), execute, the stack writes (up to two),
// then the result. A divide by a nonzero divisor and, for a non power-of-two
// program depth, a call, a jump or a nonzero-level return use the divider.
// Reset clears stack top, pc and frame display; memory words 0 and 1 read zero
// until written. A stalled result holds the next result in its result state.
// ----------------------------------------------------------------------------
module stack_machine_execute_top
    import sme_pkg::*;
#(
    parameter int MEM_WORDS   = MEM_WORDS_DEF,
    parameter int NEST_LEVELS = NEST_LEVELS_DEF,
    parameter int PROG_DEPTH  = PROG_DEPTH_DEF
) (
    input logic      clk,
    input logic      rst_n,
    sme_cmd_if.sink  cmd,
    sme_rsp_if.source rsp
);
    localparam int AW = $clog2(MEM_WORDS);
    localparam int LW = $clog2(NEST_LEVELS);
    localparam int PW = $clog2(PROG_DEPTH);
    localparam int SW = CALC_W;
    localparam bit PD_POW2 = (PROG_DEPTH & (PROG_DEPTH - 1)) == 0;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_W0   = 3'd4;
    localparam logic [2:0] S_W1   = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    typedef logic signed [SW-1:0] saddr_t;

    function automatic logic in_mem(input saddr_t a);
        in_mem = (a >= 0) && (a < $signed(SW'(MEM_WORDS)));
    endfunction

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [AW-1:0] sp_reg;
    logic [PW-1:0] pc_reg;
    logic [AW-1:0] display_reg [NEST_LEVELS];
    logic          seen0_reg;
    logic          seen1_reg;

    logic [FUNC_W-1:0]        func_reg;
    logic                     lvl_nz_reg;
    logic [LW-1:0]            didx_reg;
    logic signed [OFF_W-1:0]  off_reg;
    word_t                    imm_reg;
    logic [1:0]               nrd_reg;
    logic [1:0]               nw_reg;
    logic [AW-1:0]            raddr_reg [3];
    logic [AW-1:0]            waddr_reg [2];
    logic [AW-1:0]            nsp_reg;
    logic [AW-1:0]            link_reg;
    logic                     bad_reg;
    logic [PW-1:0]            pc_inc_reg;
    logic [1:0]               rcnt_reg;
    logic                     zmask_reg;
    word_t                    t_reg [3];
    word_t                    wdata0_reg;
    word_t                    wdata1_reg;

    logic [PW-1:0]            res_pc_reg;
    logic                     res_halt_reg;
    logic                     res_pv_reg;
    logic [KIND_W-1:0]        res_kind_reg;
    word_t                    res_val_reg;
    logic [ERR_W-1:0]         res_err_reg;

    logic                     out_valid_reg;
    logic [PC_OUT_W-1:0]      out_pc_reg;
    logic                     out_halt_reg;
    logic                     out_pv_reg;
    logic [KIND_W-1:0]        out_kind_reg;
    word_t                    out_val_reg;
    logic [ERR_W-1:0]         out_err_reg;

    // decode
    logic          accept;
    logic [31:0]   lvl_in;
    logic          lvl_ok;
    logic          lvl1_ok;
    logic [LW-1:0] lvl_idx;
    logic [LW-1:0] lvl1_idx;
    logic [AW-1:0] disp_l;
    logic [AW-1:0] link_l;
    saddr_t        sp_s;
    saddr_t        off_s;
    saddr_t        imm_s;
    saddr_t        dl_s;
    saddr_t        d_r [3];
    saddr_t        d_w [2];
    saddr_t        d_nsp;
    logic [1:0]    d_nrd;
    logic [1:0]    d_nw;
    logic          d_lvl_bad;
    logic          d_bad;
    logic [PW:0]   pc_p1;
    logic [PW-1:0] pc_inc;

    // execute
    logic           is_ret_nz;
    word_t          opa;
    word_t          opb;
    word_t          quot_s;
    word_t          alu_r;
    word_t          wv;
    logic           need_div;
    logic           div_start;
    word_t          div_dividend;
    word_t          div_divisor;
    logic           div_done;
    word_t          div_quot;
    word_t          div_rem;
    logic [PW-1:0]  rm;
    logic [PW-1:0]  wrap_res;
    logic [PW-1:0]  npc_sel;
    logic [PW-1:0]  npc_final;
    logic           ret_a_bad;
    logic           dz;
    logic [ERR_W-1:0] err;
    logic           commit;
    logic           fin;
    word_t          wdata0;
    logic           is_print;
    logic [PW+PC_OUT_W-1:0] pc_wide;

    // memory port
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    word_t         ram_wdata;
    word_t         ram_rdata;
    logic          rd_issue;
    logic          out_load;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);

    assign lvl_in   = {29'd0, cmd.level};
    assign lvl_ok   = lvl_in < 32'(NEST_LEVELS);
    assign lvl1_ok  = (lvl_in + 32'd1) < 32'(NEST_LEVELS);
    assign lvl_idx  = LW'(cmd.level);
    assign lvl1_idx = LW'({1'b0, cmd.level} + 4'd1);
    assign disp_l   = lvl_ok ? display_reg[lvl_idx] : '0;
    assign link_l   = lvl1_ok ? display_reg[lvl1_idx] : '0;
    assign sp_s     = $signed(SW'(sp_reg));
    assign off_s    = SW'(cmd.offset_or_target);
    assign imm_s    = SW'(cmd.imm);
    assign dl_s     = $signed(SW'(disp_l));
    assign pc_p1    = {1'b0, pc_reg} + 1'b1;
    assign pc_inc   = (pc_p1 == (PW+1)'(PROG_DEPTH)) ? '0 : pc_p1[PW-1:0];

    always_comb
    begin
        d_nrd     = 2'd0;
        d_nw      = 2'd0;
        d_r[0]    = sp_s - 1;
        d_r[1]    = sp_s - 1;
        d_r[2]    = sp_s - 1;
        d_w[0]    = sp_s;
        d_w[1]    = sp_s + 1;
        d_nsp     = sp_s;
        d_lvl_bad = 1'b0;
        unique case (cmd.func)
            OP_LIT:
            begin
                d_nw  = 2'd1;
                d_nsp = sp_s + 1;
            end
            OP_LOAD:
            begin
                if (!lvl_ok)
                begin
                    d_lvl_bad = 1'b1;
                end
                else
                begin
                    d_nrd  = 2'd1;
                    d_r[0] = dl_s + off_s;
                    d_nw   = 2'd1;
                    d_nsp  = sp_s + 1;
                end
            end
            OP_STORE:
            begin
                if (!lvl_ok)
                begin
                    d_lvl_bad = 1'b1;
                end
                else
                begin
                    d_nrd  = 2'd1;
                    d_nw   = 2'd1;
                    d_w[0] = dl_s + off_s;
                    d_nsp  = sp_s - 1;
                end
            end
            OP_CALL:
            begin
                if (!lvl1_ok)
                begin
                    d_lvl_bad = 1'b1;
                end
                else
                begin
                    d_nw = 2'd2;
                end
            end
            OP_RET:
            begin
                if (!lvl_ok)
                begin
                    d_lvl_bad = 1'b1;
                end
                else if (cmd.level != '0)
                begin
                    d_nrd  = 2'd3;
                    d_r[1] = dl_s;
                    d_r[2] = dl_s + 1;
                    d_nw   = 2'd1;
                    d_w[0] = dl_s - off_s;
                    d_nsp  = dl_s - off_s + 1;
                end
                else
                begin
                    d_nrd = 2'd1;
                    d_nsp = $signed(SW'(display_reg[0]));
                end
            end
            OP_INC:
            begin
                d_nsp = sp_s + imm_s;
            end
            OP_JPC, OP_PRINT:
            begin
                d_nrd = 2'd1;
                d_nsp = sp_s - 1;
            end
            OP_NEG:
            begin
                d_nrd  = 2'd1;
                d_nw   = 2'd1;
                d_w[0] = sp_s - 1;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT, OP_GT, OP_NE, OP_LE, OP_GE:
            begin
                d_nrd  = 2'd2;
                d_r[0] = sp_s - 2;
                d_nw   = 2'd1;
                d_w[0] = sp_s - 2;
                d_nsp  = sp_s - 1;
            end
            default:
            begin
                d_nrd = 2'd0;
            end
        endcase
        d_bad = d_lvl_bad || !in_mem(d_nsp)
             || ((d_nrd > 2'd0) && !in_mem(d_r[0]))
             || ((d_nrd > 2'd1) && !in_mem(d_r[1]))
             || ((d_nrd > 2'd2) && !in_mem(d_r[2]))
             || ((d_nw > 2'd0) && !in_mem(d_w[0]))
             || ((d_nw > 2'd1) && !in_mem(d_w[1]));
    end

    // execute
    assign is_ret_nz = (func_reg == OP_RET) && lvl_nz_reg;
    assign opa       = t_reg[0];
    assign opb       = t_reg[1];
    assign quot_s    = (opa[DATA_W-1] ^ opb[DATA_W-1]) ? (~div_quot + 1'b1) : div_quot;

    always_comb
    begin
        unique case (func_reg)
            OP_ADD:  alu_r = opa + opb;
            OP_SUB:  alu_r = opa - opb;
            OP_MUL:  alu_r = DATA_W'(opa * opb);
            OP_DIV:  alu_r = quot_s;
            OP_EQ:   alu_r = DATA_W'(opa == opb);
            OP_LT:   alu_r = DATA_W'($signed(opa) < $signed(opb));
            OP_GT:   alu_r = DATA_W'($signed(opa) > $signed(opb));
            OP_NE:   alu_r = DATA_W'(opa != opb);
            OP_LE:   alu_r = DATA_W'($signed(opa) <= $signed(opb));
            OP_GE:   alu_r = DATA_W'($signed(opa) >= $signed(opb));
            default: alu_r = '0;
        endcase
    end

    always_comb
    begin
        priority if (func_reg == OP_CALL)
        begin
            wv = DATA_W'(off_reg);
        end
        else if (func_reg == OP_RET)
        begin
            wv = t_reg[2];
        end
        else
        begin
            wv = imm_reg;
        end
    end

    assign need_div = !bad_reg
        && (((func_reg == OP_DIV) && (opb != '0))
            || (!PD_POW2 && ((func_reg == OP_CALL) || (func_reg == OP_JMP)
                             || (func_reg == OP_JPC) || is_ret_nz)));
    assign div_start    = (state_reg == S_EXEC) && need_div;
    assign div_dividend = (func_reg == OP_DIV) ? abs_mag(opa) : abs_mag(wv);
    assign div_divisor  = (func_reg == OP_DIV) ? abs_mag(opb) : DATA_W'(PROG_DEPTH);

    sme_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign rm = div_rem[PW-1:0];

    always_comb
    begin
        if (PD_POW2)
        begin
            wrap_res = wv[PW-1:0];
        end
        else if (wv[DATA_W-1] && (rm != '0))
        begin
            wrap_res = PW'(PROG_DEPTH) - rm;
        end
        else
        begin
            wrap_res = rm;
        end
    end

    always_comb
    begin
        unique case (func_reg)
            OP_CALL: npc_sel = wrap_res;
            OP_RET:  npc_sel = lvl_nz_reg ? wrap_res : '0;
            OP_JMP:  npc_sel = wrap_res;
            OP_JPC:  npc_sel = (opa == '0) ? wrap_res : pc_inc_reg;
            default: npc_sel = pc_inc_reg;
        endcase
    end

    assign ret_a_bad = is_ret_nz
        && !(!t_reg[1][DATA_W-1] && (t_reg[1] < DATA_W'(MEM_WORDS)));
    assign dz        = (func_reg == OP_DIV) && (opb == '0);

    always_comb
    begin
        priority if (bad_reg || ret_a_bad)
        begin
            err = ERR_RANGE;
        end
        else if (dz)
        begin
            err = ERR_DIV0;
        end
        else
        begin
            err = ERR_NONE;
        end
    end

    assign commit    = (err == ERR_NONE);
    assign npc_final = (func_reg == OP_END) ? pc_reg : (commit ? npc_sel : pc_inc_reg);
    assign fin       = ((state_reg == S_EXEC) && !need_div) || ((state_reg == S_DIV) && div_done);
    assign is_print  = (func_reg == OP_PRINT) || (func_reg == OP_NL) || (func_reg == OP_SPACE);

    always_comb
    begin
        unique case (func_reg)
            OP_LIT:  wdata0 = imm_reg;
            OP_CALL: wdata0 = DATA_W'(link_reg);
            OP_NEG:  wdata0 = ~opa + 1'b1;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_LT, OP_GT, OP_NE, OP_LE, OP_GE:
            begin
                wdata0 = alu_r;
            end
            default: wdata0 = opa;
        endcase
    end

    // memory port
    assign rd_issue = (state_reg == S_RD) && (rcnt_reg < nrd_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = '0;
        ram_wdata = wdata0_reg;
        if (rd_issue)
        begin
            ram_addr = raddr_reg[rcnt_reg];
        end
        else if (state_reg == S_W0)
        begin
            ram_we   = 1'b1;
            ram_addr = waddr_reg[0];
        end
        else if (state_reg == S_W1)
        begin
            ram_we    = 1'b1;
            ram_addr  = waddr_reg[1];
            ram_wdata = wdata1_reg;
        end
    end

    sme_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (d_nrd != 2'd0) ? S_RD : S_EXEC;
                end
            end
            S_RD:
            begin
                if (rcnt_reg == nrd_reg)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC, S_DIV:
            begin
                if (div_start)
                begin
                    state_next = S_DIV;
                end
                else if (fin)
                begin
                    state_next = (commit && (nw_reg != 2'd0)) ? S_W0 : S_OUT;
                end
            end
            S_W0:
            begin
                state_next = (nw_reg == 2'd2) ? S_W1 : S_OUT;
            end
            S_W1:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            pc_reg        <= '0;
            seen0_reg     <= 1'b0;
            seen1_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            rcnt_reg      <= '0;
            for (int i = 0; i < NEST_LEVELS; i++)
            begin
                display_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                rcnt_reg <= '0;
            end
            else if ((state_reg == S_RD) && (rcnt_reg != nrd_reg))
            begin
                rcnt_reg <= rcnt_reg + 1'b1;
            end
            if (ram_we && (ram_addr == AW'(0)))
            begin
                seen0_reg <= 1'b1;
            end
            if (ram_we && (ram_addr == AW'(1)))
            begin
                seen1_reg <= 1'b1;
            end
            if (fin)
            begin
                pc_reg <= npc_final;
                if (commit)
                begin
                    sp_reg <= nsp_reg;
                    if (func_reg == OP_CALL)
                    begin
                        display_reg[didx_reg] <= sp_reg;
                    end
                    else if (is_ret_nz)
                    begin
                        display_reg[didx_reg] <= t_reg[1][AW-1:0];
                    end
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign pc_wide = {PC_OUT_W'(0), res_pc_reg};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg     <= cmd.func;
            lvl_nz_reg   <= (cmd.level != '0);
            didx_reg     <= (cmd.func == OP_CALL) ? lvl1_idx : lvl_idx;
            off_reg      <= cmd.offset_or_target;
            imm_reg      <= cmd.imm;
            nrd_reg      <= d_nrd;
            nw_reg       <= d_nw;
            raddr_reg[0] <= AW'(d_r[0]);
            raddr_reg[1] <= AW'(d_r[1]);
            raddr_reg[2] <= AW'(d_r[2]);
            waddr_reg[0] <= AW'(d_w[0]);
            waddr_reg[1] <= AW'(d_w[1]);
            nsp_reg      <= AW'(d_nsp);
            link_reg     <= link_l;
            bad_reg      <= d_bad;
            pc_inc_reg   <= pc_inc;
            t_reg[0]     <= '0;
        end
        if (rd_issue)
        begin
            zmask_reg <= ((ram_addr == AW'(0)) && !seen0_reg)
                      || ((ram_addr == AW'(1)) && !seen1_reg);
        end
        if ((state_reg == S_RD) && (rcnt_reg != 2'd0))
        begin
            t_reg[rcnt_reg - 2'd1] <= zmask_reg ? '0 : ram_rdata;
        end
        if (fin)
        begin
            wdata0_reg   <= wdata0;
            wdata1_reg   <= DATA_W'(pc_inc_reg);
            res_pc_reg   <= npc_final;
            res_halt_reg <= (func_reg == OP_END) || (npc_final == '0);
            res_pv_reg   <= commit && is_print;
            res_err_reg  <= (func_reg == OP_END) ? ERR_NONE : err;
            res_val_reg  <= (commit && (func_reg == OP_PRINT)) ? opa : '0;
            if (commit && (func_reg == OP_NL))
            begin
                res_kind_reg <= KIND_NEWLINE;
            end
            else if (commit && (func_reg == OP_SPACE))
            begin
                res_kind_reg <= KIND_SPACE;
            end
            else
            begin
                res_kind_reg <= KIND_VALUE;
            end
        end
        if (out_load)
        begin
            out_pc_reg   <= pc_wide[PC_OUT_W-1:0];
            out_halt_reg <= res_halt_reg;
            out_pv_reg   <= res_pv_reg;
            out_kind_reg <= res_kind_reg;
            out_val_reg  <= res_val_reg;
            out_err_reg  <= res_err_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.next_pc     = out_pc_reg;
    assign rsp.halted      = out_halt_reg;
    assign rsp.print_valid = out_pv_reg;
    assign rsp.print_kind  = out_kind_reg;
    assign rsp.print_value = out_val_reg;
    assign rsp.error       = out_err_reg;
endmodule
